// ===== rtl/tisp_pkg.sv =====
// Package for the telnet IAC stream parser: telnet byte codes, result kinds,
// the result record and the request/response records of the shared step unit.
// Depends on nothing.
`timescale 1ns / 1ps

package tisp_pkg;

	localparam int LEN_W = 6;

	localparam logic [7:0] BYTE_IAC  = 8'hFF;
	localparam logic [7:0] BYTE_DONT = 8'hFE;
	localparam logic [7:0] BYTE_DO   = 8'hFD;
	localparam logic [7:0] BYTE_WONT = 8'hFC;
	localparam logic [7:0] BYTE_WILL = 8'hFB;
	localparam logic [7:0] BYTE_SB   = 8'hFA;
	localparam logic [7:0] BYTE_SE   = 8'hF0;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_OPTION  = 2'd1;
	localparam logic [1:0] KIND_HEADER  = 2'd2;
	localparam logic [1:0] KIND_PAYLOAD = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       byte_value;
		logic [7:0]       option_code;
		logic [1:0]       negotiation;
		logic [LEN_W-1:0] payload_length;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [LEN_W-1:0] a;
		logic [LEN_W-1:0] bound;
	} step_req_t;

	typedef struct packed {
		logic [LEN_W-1:0] inc;
		logic             below;
		logic             hits;
	} step_rsp_t;

endpackage

// ===== rtl/tisp_if.sv =====
// Valid/ready channel interfaces of the telnet IAC stream parser.
// Depends on tisp_pkg for the payload length width.
`timescale 1ns / 1ps

interface tisp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface tisp_res_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic [7:0]                byte_value;
	logic [7:0]                option_code;
	logic [1:0]                negotiation;
	logic [tisp_pkg::LEN_W-1:0] payload_length;
	logic                      last;

	modport source(output valid, output kind, output byte_value, output option_code,
		output negotiation, output payload_length, output last, input ready);
	modport sink(input valid, input kind, input byte_value, input option_code,
		input negotiation, input payload_length, input last, output ready);
endinterface

// ===== rtl/telnet_iac_stream_parser.sv =====
// Top level of the telnet IAC stream parser: parse sequencer, payload store,
// shared step unit and output register. Depends on tisp_pkg, tisp_if,
// tisp_ram and tisp_step.
//
//   channel | dir | payload                                              | handshake
//   rx      | in  | rx_byte                                              | valid/ready
//   res     | out | kind, byte_value, option_code, negotiation,          | valid/ready
//           |     | payload_length, last                                 |
//
// Each received byte is taken on its rx handshake; every byte except a closing
// IAC SE gives at most one result. IAC SE closing a subnegotiation of N payload
// bytes gives the header, then replays the store byte by byte, each byte first
// read (registered RAM read port) and then sent, so rx is held off for the
// replay plus result stalls. Reset clears the parser to the data state; the
// store is not cleared. A stalled res holds rx off until the result leaves.
`timescale 1ns / 1ps

module telnet_iac_stream_parser #(
	parameter int SUBNEG_CAPACITY = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	tisp_rx_if.sink        rx,
	tisp_res_if.source     res
);

	localparam int DEPTH = SUBNEG_CAPACITY - 1;
	localparam int CNT_W = $clog2(SUBNEG_CAPACITY);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_DATA    = 3'd0;
	localparam logic [2:0] ST_IAC     = 3'd1;
	localparam logic [2:0] ST_VERB    = 3'd2;
	localparam logic [2:0] ST_SB_OPT  = 3'd3;
	localparam logic [2:0] ST_SB_BODY = 3'd4;
	localparam logic [2:0] ST_SB_IAC0 = 3'd5;
	localparam logic [2:0] ST_SB_IAC1 = 3'd6;
	localparam logic [2:0] ST_DUMP    = 3'd7;

	logic [2:0]       state_q, nx_state;
	logic [1:0]       verb_q, nx_verb;
	logic [7:0]       opt_q, nx_opt;
	logic [CNT_W-1:0] cnt_q, nx_cnt;
	logic [CNT_W-1:0] len_q, nx_len;
	logic [CNT_W-1:0] idx_q, nx_idx;
	logic             rd_ok_q, nx_rd_ok;
	logic             out_vld_q;
	tisp_pkg::result_t out_q, res_d;

	logic             slot_free;
	logic             rx_rdy;
	logic             rx_fire;
	logic             emit;
	logic             we;
	logic [7:0]       rdata;
	logic [7:0]       b;
	tisp_pkg::step_req_t step_req;
	tisp_pkg::step_rsp_t step_rsp;

	assign slot_free = !out_vld_q || res.ready;
	assign rx_rdy    = (state_q != ST_DUMP) && slot_free;
	assign rx.ready  = rx_rdy;
	assign rx_fire   = rx.valid && rx_rdy;
	assign b         = rx.rx_byte;

	always_comb begin
		if (state_q == ST_DUMP) begin
			step_req.a     = tisp_pkg::LEN_W'(idx_q);
			step_req.bound = tisp_pkg::LEN_W'(len_q);
		end else begin
			step_req.a     = tisp_pkg::LEN_W'(cnt_q);
			step_req.bound = tisp_pkg::LEN_W'(DEPTH);
		end
	end

	tisp_step u_step (
		.req (step_req),
		.rsp (step_rsp)
	);

	tisp_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (b),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		nx_state = state_q;
		nx_verb  = verb_q;
		nx_opt   = opt_q;
		nx_cnt   = cnt_q;
		nx_len   = len_q;
		nx_idx   = idx_q;
		nx_rd_ok = rd_ok_q;
		emit     = 1'b0;
		we       = 1'b0;
		res_d    = '0;
		if (state_q == ST_DUMP) begin
			if (!rd_ok_q) begin
				nx_rd_ok = 1'b1;
			end else if (slot_free) begin
				emit             = 1'b1;
				res_d.kind       = tisp_pkg::KIND_PAYLOAD;
				res_d.byte_value = rdata;
				res_d.last       = step_rsp.hits;
				nx_idx           = step_rsp.inc[CNT_W-1:0];
				nx_rd_ok         = 1'b0;
				if (step_rsp.hits) begin
					nx_state = ST_DATA;
				end
			end
		end else if (rx_fire) begin
			unique case (state_q) inside
				ST_IAC: begin
					if (b == tisp_pkg::BYTE_IAC) begin
						emit             = 1'b1;
						res_d.kind       = tisp_pkg::KIND_DATA;
						res_d.byte_value = tisp_pkg::BYTE_IAC;
						res_d.last       = 1'b1;
						nx_state         = ST_DATA;
					end else if (b == tisp_pkg::BYTE_SB) begin
						nx_cnt   = '0;
						nx_state = ST_SB_OPT;
					end else if (b >= tisp_pkg::BYTE_WILL && b <= tisp_pkg::BYTE_DONT) begin
						nx_verb  = 2'(b - tisp_pkg::BYTE_WILL);
						nx_state = ST_VERB;
					end else begin
						nx_state = ST_DATA;
					end
				end
				ST_VERB: begin
					emit              = 1'b1;
					res_d.kind        = tisp_pkg::KIND_OPTION;
					res_d.option_code = b;
					res_d.negotiation = verb_q;
					res_d.last        = 1'b1;
					nx_state          = ST_DATA;
				end
				ST_SB_OPT: begin
					if (b == tisp_pkg::BYTE_IAC) begin
						nx_state = ST_SB_IAC0;
					end else begin
						nx_opt   = b;
						nx_state = ST_SB_BODY;
					end
				end
				ST_SB_BODY: begin
					if (b == tisp_pkg::BYTE_IAC) begin
						nx_state = ST_SB_IAC1;
					end else if (step_rsp.below) begin
						we     = 1'b1;
						nx_cnt = step_rsp.inc[CNT_W-1:0];
					end
				end
				ST_SB_IAC0, ST_SB_IAC1: begin
					if (b == tisp_pkg::BYTE_SE) begin
						nx_len            = (state_q == ST_SB_IAC0) ? '0 : cnt_q;
						emit              = 1'b1;
						res_d.kind        = tisp_pkg::KIND_HEADER;
						res_d.option_code = opt_q;
						res_d.payload_length = tisp_pkg::LEN_W'(nx_len);
						res_d.last        = (nx_len == '0);
						nx_idx            = '0;
						nx_rd_ok          = 1'b0;
						nx_state          = (nx_len == '0) ? ST_DATA : ST_DUMP;
					end else begin
						nx_state = (state_q == ST_SB_IAC0) ? ST_SB_OPT : ST_SB_BODY;
					end
				end
				default: begin
					if (b == tisp_pkg::BYTE_IAC) begin
						nx_state = ST_IAC;
					end else begin
						emit             = 1'b1;
						res_d.kind       = tisp_pkg::KIND_DATA;
						res_d.byte_value = b;
						res_d.last       = 1'b1;
						nx_state         = ST_DATA;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_DATA;
			verb_q    <= '0;
			opt_q     <= '0;
			cnt_q     <= '0;
			len_q     <= '0;
			idx_q     <= '0;
			rd_ok_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= nx_state;
			verb_q  <= nx_verb;
			opt_q   <= nx_opt;
			cnt_q   <= nx_cnt;
			len_q   <= nx_len;
			idx_q   <= nx_idx;
			rd_ok_q <= nx_rd_ok;
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res_d;
		end
	end

	assign res.valid          = out_vld_q;
	assign res.kind           = out_q.kind;
	assign res.byte_value     = out_q.byte_value;
	assign res.option_code    = out_q.option_code;
	assign res.negotiation    = out_q.negotiation;
	assign res.payload_length = out_q.payload_length;
	assign res.last           = out_q.last;

endmodule

// ===== rtl/tisp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module tisp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 31
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tisp_step.sv =====
// Shared step unit: increment, bound compare and end-of-run compare.
// Serves the payload fill counter and the replay index. Depends on tisp_pkg.
`timescale 1ns / 1ps

module tisp_step (
	input  tisp_pkg::step_req_t req,
	output tisp_pkg::step_rsp_t rsp
);

	always_comb begin
		rsp.inc   = req.a + tisp_pkg::LEN_W'(1);
		rsp.below = req.a < req.bound;
		rsp.hits  = rsp.inc == req.bound;
	end

endmodule

// ===== rtl/tisp_chk.sv =====
// Port-level checker of the telnet IAC stream parser and its bind.
// Depends on tisp_pkg and telnet_iac_stream_parser.
`timescale 1ns / 1ps

module tisp_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [1:0]                 res_kind,
	input logic [7:0]                 res_byte_value,
	input logic [tisp_pkg::LEN_W-1:0] res_payload_length,
	input logic                       res_last
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_kind) && $stable(res_byte_value)
		&& $stable(res_payload_length) && $stable(res_last))
		else $error("result changed while stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == tisp_pkg::KIND_DATA || res_kind == tisp_pkg::KIND_OPTION)
		|-> res_last)
		else $error("data or option result without last");

	a_header_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == tisp_pkg::KIND_HEADER
		|-> res_last == (res_payload_length == '0))
		else $error("header last mark disagrees with length");

endmodule

bind telnet_iac_stream_parser tisp_chk u_tisp_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_kind           (res.kind),
	.res_byte_value     (res.byte_value),
	.res_payload_length (res.payload_length),
	.res_last           (res.last)
);

// ===== verif/tisp_result_checker.sv =====
// Result checker for the telnet IAC stream parser: watches the rx and res channels,
// predicts every result from the accepted bytes and compares it field by field.
// Depends on tisp_pkg and tisp_if.
`timescale 1ns / 1ps

module tisp_result_checker #(
	parameter int SUBNEG_CAPACITY = 32
) (
	input  logic clk,
	input  logic arst_n,
	tisp_rx_if   rx,
	tisp_res_if  res,
	output int   fail_count,
	output int   checked_count,
	output int   pending_count
);
	import tisp_pkg::*;

	typedef enum logic [2:0] {
		PS_DATA,
		PS_IAC,
		PS_VERB,
		PS_SB_OPT,
		PS_SB_BODY,
		PS_SB_IAC0,
		PS_SB_IAC1
	} parse_state_t;

	localparam int STORE_DEPTH = SUBNEG_CAPACITY - 1;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	parse_state_t parse_state;
	logic [1:0]   pending_verb;
	logic [7:0]   subneg_option;
	int           subneg_count;
	logic [7:0]   subneg_bytes [STORE_DEPTH];
	result_t      pending_results [$];
	int           errors;
	int           checked;

	assign fail_count    = errors;
	assign checked_count = checked;

	function automatic result_t make_result(logic [1:0] kind, logic [7:0] value,
		logic [7:0] option, logic [1:0] verb, logic [LEN_W-1:0] length, logic fin);
		result_t r;
		r.kind           = kind;
		r.byte_value     = value;
		r.option_code    = option;
		r.negotiation    = verb;
		r.payload_length = length;
		r.last           = fin;
		return r;
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b);
		int length;
		case (parse_state) inside
			PS_IAC: begin
				if (b == BYTE_IAC) begin
					pending_results.push_back(make_result(KIND_DATA, BYTE_IAC, '0, '0, '0,
						1'b1));
					parse_state = PS_DATA;
				end else if (b == BYTE_SB) begin
					subneg_count = 0;
					parse_state  = PS_SB_OPT;
				end else if (b >= BYTE_WILL && b <= BYTE_DONT) begin
					pending_verb = 2'(b - BYTE_WILL);
					parse_state  = PS_VERB;
				end else begin
					parse_state = PS_DATA;
				end
			end
			PS_VERB: begin
				pending_results.push_back(make_result(KIND_OPTION, '0, b, pending_verb, '0,
					1'b1));
				parse_state = PS_DATA;
			end
			PS_SB_OPT: begin
				if (b == BYTE_IAC) begin
					parse_state = PS_SB_IAC0;
				end else begin
					subneg_option = b;
					parse_state   = PS_SB_BODY;
				end
			end
			PS_SB_BODY: begin
				if (b == BYTE_IAC) begin
					parse_state = PS_SB_IAC1;
				end else if (subneg_count < STORE_DEPTH) begin
					subneg_bytes[IDX_W'(subneg_count)] = b;
					subneg_count++;
				end
			end
			PS_SB_IAC0, PS_SB_IAC1: begin
				if (b == BYTE_SE) begin
					length = (parse_state == PS_SB_IAC0) ? 0 : subneg_count;
					pending_results.push_back(make_result(KIND_HEADER, '0, subneg_option, '0,
						LEN_W'(length), length == 0));
					for (int i = 0; i < length; i++)
						pending_results.push_back(make_result(KIND_PAYLOAD,
							subneg_bytes[IDX_W'(i)], '0, '0, '0, i + 1 == length));
					parse_state = PS_DATA;
				end else begin
					parse_state = (parse_state == PS_SB_IAC0) ? PS_SB_OPT : PS_SB_BODY;
				end
			end
			default: begin
				if (b == BYTE_IAC) begin
					parse_state = PS_IAC;
				end else begin
					pending_results.push_back(make_result(KIND_DATA, b, '0, '0, '0, 1'b1));
					parse_state = PS_DATA;
				end
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		checked++;
		if (pending_results.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual %p", $time, got);
		end else begin
			want = pending_results.pop_front();
			compare_field("kind", 8'(want.kind), 8'(got.kind));
			compare_field("byte_value", want.byte_value, got.byte_value);
			compare_field("option_code", want.option_code, got.option_code);
			compare_field("negotiation", 8'(want.negotiation), 8'(got.negotiation));
			compare_field("payload_length", 8'(want.payload_length),
				8'(got.payload_length));
			compare_field("last", 8'(want.last), 8'(got.last));
		end
	endtask

	initial begin
		errors  = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_state   = PS_DATA;
			pending_verb  = '0;
			subneg_option = '0;
			subneg_count  = 0;
			pending_results.delete();
			pending_count <= 0;
		end else begin
			if (rx.valid && rx.ready)
				parse_rx_byte(rx.rx_byte);
			if (res.valid && res.ready)
				check_result({res.kind, res.byte_value, res.option_code, res.negotiation,
					res.payload_length, res.last});
			pending_count <= pending_results.size();
		end
	end

endmodule

// ===== verif/telnet_iac_stream_parser_tb.sv =====
// Testbench top for the telnet IAC stream parser: drives telnet byte streams with
// random gaps and result stalls, and gives the verdict from tisp_result_checker.
// Depends on tisp_pkg, tisp_if, tisp_result_checker and the parser RTL.
`timescale 1ns / 1ps

module telnet_iac_stream_parser_tb;
	import tisp_pkg::*;

	localparam int CAPACITY   = 32;
	localparam int BYTE_COUNT = 430;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   checked_count;
	int   pending_count;
	int   bytes_sent;
	int   subneg_sent;
	int   res_taken;
	int   res_draw;
	int   stall_left;
	bit   rx_quiet;
	bit   res_quiet;

	tisp_rx_if  rx_ch ();
	tisp_res_if res_ch ();

	telnet_iac_stream_parser #(
		.SUBNEG_CAPACITY(CAPACITY)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	tisp_result_checker #(
		.SUBNEG_CAPACITY(CAPACITY)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx_ch),
		.res           (res_ch),
		.fail_count    (fail_count),
		.checked_count (checked_count),
		.pending_count (pending_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// stall the result side per result, with quiet stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else if (res_ch.valid && res_ch.ready) begin
			res_taken++;
			if (res_taken % 30 == 0)
				res_quiet = ($urandom_range(0, 3) == 0);
			res_draw = res_quiet ? 0 : $urandom_range(0, 8);
			stall_left   <= res_draw;
			res_ch.ready <= (res_draw == 0);
		end else if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			res_ch.ready <= (stall_left == 1);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic send_rx_byte(input logic [7:0] b);
		int gap;
		if (bytes_sent % 40 == 0)
			rx_quiet = ($urandom_range(0, 3) == 0);
		gap = rx_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	function automatic logic [7:0] not_se_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == BYTE_SE) ? BYTE_SE + 8'd1 : b;
	endfunction

	task automatic send_subneg();
		int length;
		subneg_sent++;
		send_rx_byte(BYTE_IAC);
		send_rx_byte(BYTE_SB);
		case ($urandom_range(0, 9))
			0: begin
				send_rx_byte(BYTE_IAC);
				send_rx_byte(BYTE_SE);
				return;
			end
			1: begin
				send_rx_byte(BYTE_IAC);
				send_rx_byte(not_se_byte());
			end
			default: ;
		endcase
		send_rx_byte(8'($urandom_range(0, 254)));
		length = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 8);
		for (int i = 0; i < length; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				send_rx_byte(BYTE_IAC);
				send_rx_byte(not_se_byte());
			end
			send_rx_byte(8'($urandom_range(0, 254)));
		end
		// leave some subnegotiations open
		if ($urandom_range(0, 11) != 0) begin
			send_rx_byte(BYTE_IAC);
			send_rx_byte(BYTE_SE);
		end
	endtask

	initial begin
		logic [7:0] opening [32] = '{
			BYTE_IAC, BYTE_SB, BYTE_IAC, BYTE_SE,
			8'h00, 8'hFE,
			BYTE_IAC, BYTE_IAC,
			BYTE_IAC, BYTE_WILL, 8'h00, BYTE_IAC, BYTE_WONT, 8'hFF,
			BYTE_IAC, BYTE_DO, 8'h80, BYTE_IAC, BYTE_DONT, 8'h7F,
			BYTE_IAC, 8'hF1,
			BYTE_IAC, BYTE_SB, BYTE_IAC, 8'h01, 8'h2A, BYTE_IAC, 8'h02, 8'h55,
			BYTE_IAC, BYTE_SE
		};
		int choice;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		bytes_sent    = 0;
		subneg_sent   = 0;
		res_taken     = 0;
		rx_quiet      = 1'b0;
		res_quiet     = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_rx_byte(opening[i]);

		while (bytes_sent < BYTE_COUNT) begin
			choice = $urandom_range(0, 99);
			if (choice < 35) begin
				send_rx_byte(8'($urandom_range(0, 254)));
			end else if (choice < 45) begin
				send_rx_byte(BYTE_IAC);
				send_rx_byte(BYTE_IAC);
			end else if (choice < 65) begin
				send_rx_byte(BYTE_IAC);
				send_rx_byte(BYTE_WILL + 8'($urandom_range(0, 3)));
				send_rx_byte(8'($urandom_range(0, 255)));
			end else if (choice < 72) begin
				send_rx_byte(BYTE_IAC);
				send_rx_byte(8'($urandom_range(0, 8'hF9)));
			end else if (choice < 92) begin
				send_subneg();
			end else begin
				send_rx_byte(8'($urandom_range(0, 255)));
			end
		end
		rx_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Summary: %0d bytes sent, %0d subnegotiations opened, %0d results checked",
			bytes_sent, subneg_sent, checked_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
